// ===== src/ultrasonic_echo_ranger_macros.svh =====
// Assertion macros used by the ultrasonic echo ranger core.
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every clock edge outside of reset.
`define UER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define UER_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define UER_ASSERT(lbl, prop, msg)
`define UER_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== src/uer_pkg.sv =====
// Shared types and constants of the ultrasonic echo ranger.
package uer_pkg;

  // Configuration port geometry.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register field widths.
  localparam int TIMEOUT_W = 12;
  localparam int SCALE_W   = 10;
  localparam int DIST_W    = 14;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_SCALE    = 2'd1;
  localparam logic [1:0] REG_MIN_DIST = 2'd2;

  // Reset values of the registers.
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 12'd2200;
  localparam logic [SCALE_W-1:0]   SCALE_RST    = 10'd696;
  localparam logic [DIST_W-1:0]    MIN_DIST_RST = 14'd40;

  // Largest reportable distance.
  localparam logic [DIST_W-1:0] DIST_MAX = 14'h3FFF;

  // Item opcodes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Configuration seen by the measurement core.
  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [SCALE_W-1:0]   mm_per_tick_q8;
    logic [DIST_W-1:0]    min_distance;
  } cfg_t;

endpackage

// ===== src/uer_regs.sv =====
// APB-style configuration registers of the ultrasonic echo ranger.
module uer_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::ADDR_W-1:0] paddr,
  input  logic [uer_pkg::DATA_W-1:0] pwdata,
  output logic [uer_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output uer_pkg::cfg_t              cfg
);

  uer_pkg::cfg_t cfg_r;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Register writes; an address past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks  <= uer_pkg::TIMEOUT_RST;
      cfg_r.mm_per_tick_q8 <= uer_pkg::SCALE_RST;
      cfg_r.min_distance   <= uer_pkg::MIN_DIST_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        uer_pkg::REG_TIMEOUT:  cfg_r.timeout_ticks  <= pwdata[uer_pkg::TIMEOUT_W-1:0];
        uer_pkg::REG_SCALE:    cfg_r.mm_per_tick_q8 <= pwdata[uer_pkg::SCALE_W-1:0];
        uer_pkg::REG_MIN_DIST: cfg_r.min_distance   <= pwdata[uer_pkg::DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (paddr[3:2])
      uer_pkg::REG_TIMEOUT:  prdata = uer_pkg::DATA_W'(cfg_r.timeout_ticks);
      uer_pkg::REG_SCALE:    prdata = uer_pkg::DATA_W'(cfg_r.mm_per_tick_q8);
      uer_pkg::REG_MIN_DIST: prdata = uer_pkg::DATA_W'(cfg_r.min_distance);
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== src/uer_core.sv =====
// Measurement core: input register, echo timing state, distance scaling, result register.
`include "ultrasonic_echo_ranger_macros.svh"

module uer_core #(
  parameter int COUNT_BITS = 13
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  uer_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  logic                       in_echo,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_trigger,
  output logic                       out_done_res,
  output logic [uer_pkg::DIST_W-1:0] out_distance_mm,
  output logic                       out_held
);

  localparam int CMP_W  = (COUNT_BITS > uer_pkg::TIMEOUT_W) ? COUNT_BITS : uer_pkg::TIMEOUT_W;
  localparam int PROD_W = COUNT_BITS + uer_pkg::SCALE_W;
  localparam int QW     = (PROD_W - 8 > uer_pkg::DIST_W + 1) ? PROD_W - 8 : uer_pkg::DIST_W + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RISE = 2'd1,
    PH_FALL = 2'd2
  } phase_t;

  // Input stage.
  logic s1_valid_r;
  logic s1_op_r;
  logic s1_echo_r;
  logic s1_adv;
  logic s1_fire;

  // Measurement state.
  phase_t                    phase_r, phase_nxt;
  logic [COUNT_BITS-1:0]     tick_r, tick_nxt;
  logic [COUNT_BITS-1:0]     rise_r, rise_nxt;
  logic [uer_pkg::DIST_W-1:0] last_dist_r, last_dist_nxt;

  // Result stage.
  logic                       out_valid_r;
  logic                       out_trigger_r, out_trigger_nxt;
  logic                       out_done_r, out_done_nxt;
  logic [uer_pkg::DIST_W-1:0] out_distance_r, out_distance_nxt;
  logic                       out_held_r, out_held_nxt;

  // Datapath.
  logic                       past_timeout;
  logic [COUNT_BITS-1:0]      tick_bump;
  logic [COUNT_BITS-1:0]      span;
  logic [PROD_W-1:0]          prod;
  logic [QW-1:0]              quo;
  logic [uer_pkg::DIST_W-1:0] dist_sat;
  logic                       below_min;

  // The input register advances whenever the result register is free or drained.
  assign s1_adv   = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r   <= in_op;
      s1_echo_r <= in_echo;
    end
  end

  // Timeout compare, saturating count increment and span scaling.
  assign past_timeout = (CMP_W'(tick_r) > CMP_W'(cfg.timeout_ticks)) || (tick_r == CNT_MAX);
  assign tick_bump    = (tick_r == CNT_MAX) ? tick_r : tick_r + 1'b1;
  assign span         = (phase_r == PH_FALL) ? tick_r - rise_r : '0;
  assign prod         = PROD_W'(span) * PROD_W'(cfg.mm_per_tick_q8);
  assign quo          = QW'(prod >> 8);
  assign dist_sat     = (quo > QW'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                       : quo[uer_pkg::DIST_W-1:0];
  assign below_min    = dist_sat < cfg.min_distance;

  // Next state and result of the item in the input register.
  always_comb begin
    phase_nxt        = phase_r;
    tick_nxt         = tick_r;
    rise_nxt         = rise_r;
    last_dist_nxt    = last_dist_r;
    out_trigger_nxt  = 1'b0;
    out_done_nxt     = 1'b0;
    out_distance_nxt = '0;
    out_held_nxt     = 1'b0;
    if (s1_op_r == uer_pkg::OP_START) begin
      out_trigger_nxt = 1'b1;
      tick_nxt        = '0;
      rise_nxt        = '0;
      phase_nxt       = PH_RISE;
    end else begin
      case (phase_r)
        PH_RISE: begin
          if (past_timeout) begin
            out_done_nxt = 1'b1;
            phase_nxt    = PH_IDLE;
          end else begin
            if (s1_echo_r) begin
              rise_nxt  = tick_r;
              phase_nxt = PH_FALL;
            end
            tick_nxt = tick_bump;
          end
        end
        PH_FALL: begin
          if (!s1_echo_r || past_timeout) begin
            out_done_nxt = 1'b1;
            phase_nxt    = PH_IDLE;
          end else begin
            tick_nxt = tick_bump;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
      // A finished measurement reports its distance or holds the last good one.
      if (out_done_nxt) begin
        if (below_min) begin
          out_distance_nxt = last_dist_r;
          out_held_nxt     = 1'b1;
        end else begin
          out_distance_nxt = dist_sat;
          last_dist_nxt    = dist_sat;
        end
      end
    end
  end

  // Measurement state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      rise_r      <= '0;
      last_dist_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        rise_r      <= rise_nxt;
        last_dist_r <= last_dist_nxt;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word payload.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_trigger_r  <= out_trigger_nxt;
      out_done_r     <= out_done_nxt;
      out_distance_r <= out_distance_nxt;
      out_held_r     <= out_held_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_trigger     = out_trigger_r;
  assign out_done_res    = out_done_r;
  assign out_distance_mm = out_distance_r;
  assign out_held        = out_held_r;

  // A start word never completes a measurement.
  `UER_ASSERT(a_start_not_done, !(out_valid_r && out_trigger_r && out_done_r), "start word marked done")
  // A word that finishes nothing carries no distance and no hold flag.
  `UER_ASSERT(a_idle_word_clean, (out_valid_r && !out_done_r) |-> (out_distance_r == '0 && !out_held_r), "non-done word carries data")
  // While waiting for the fall the rise count never passes the tick count.
  `UER_ASSERT(a_rise_le_tick, (phase_r == PH_FALL) |-> (rise_r <= tick_r), "rise count ahead of tick count")
  // A processed start word rearms the timer.
  `UER_ASSERT(a_start_rearms, (s1_fire && s1_op_r == uer_pkg::OP_START) |=> (phase_r == PH_RISE && tick_r == '0), "start did not rearm")

endmodule

// ===== src/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger: takes one tick or start word per clock cycle while the result side
// is not stalled and returns one result word for each. Each word is registered on entry, then
// passes one stage of compare, saturating count and a single COUNT_BITS by 10 bit multiply
// into the result register, which also updates the timing state; the handshake sustains one
// word per cycle while the result side is not stalled. A start word raises trigger and arms the
// timer; tick words sample echo; the word that sees the fall or the timeout carries done_res
// and the distance in mm (span times mm_per_tick_q8 / 256, saturated to 14 bits, or the last
// good distance with held set when below min_distance). Registers sit at byte offsets 0
// (timeout_ticks), 4 (mm_per_tick_q8) and 8 (min_distance) and should be written while idle.
module ultrasonic_echo_ranger #(
  parameter int COUNT_BITS = 13
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::ADDR_W-1:0] paddr,
  input  logic [uer_pkg::DATA_W-1:0] pwdata,
  output logic [uer_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  logic                       in_echo,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_trigger,
  output logic                       out_done_res,
  output logic [uer_pkg::DIST_W-1:0] out_distance_mm,
  output logic                       out_held
);

  uer_pkg::cfg_t cfg;

  // Configuration registers.
  uer_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Measurement pipeline.
  uer_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_echo         (in_echo),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_trigger     (out_trigger),
    .out_done_res    (out_done_res),
    .out_distance_mm (out_distance_mm),
    .out_held        (out_held)
  );

endmodule
